// File: rtl/fgr_pkg.sv
// ----------------------------------------------------------------------------
// fgr_pkg
// Shared types, constants and the 5x7 glyph table of the glyph rasterizer.
// ----------------------------------------------------------------------------
package fgr_pkg;

	localparam int unsigned MAX_SCREEN_DIM_DEF = 1024;
	localparam int unsigned PIX_SPAN = 1024;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned PIX_W = 10;
	localparam int unsigned ADDR_W = 20;
	localparam int unsigned DIM_W = 11;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned GLYPH_COLS = 5;
	localparam int unsigned GLYPH_ROWS = 7;
	localparam int unsigned GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
	localparam int unsigned GLYPH_COUNT = 95;

	localparam logic [CODE_W-1:0] CHAR_FIRST = 8'h20;
	localparam logic [CODE_W-1:0] CHAR_LAST = 8'h7E;
	localparam logic signed [COORD_W-1:0] CHAR_ADVANCE = 12'sd6;
	localparam logic signed [COORD_W-1:0] CURSOR_TOP = 12'sd2047;

	localparam logic [DIM_W-1:0] WIDTH_RST = 11'd160;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd128;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	typedef logic [GLYPH_BITS-1:0] glyph_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} fgr_cmd_t;

	typedef struct packed {
		logic step_ok;
		logic last_cell;
		logic flush_ok;
	} fgr_stat_t;

	// Column bytes, first column in the top byte, bit 0 is the top row
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700,
		40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001C224100,
		40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
		40'h4261514946, 40'h2141454B31, 40'h1814127F10,
		40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000,
		40'h0056360000, 40'h0008142241, 40'h1414141414,
		40'h4122140800, 40'h0201510906, 40'h324979413E,
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
		40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
		40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
		40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
		40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
		40'h0304780403, 40'h6151494543, 40'h00007F4141,
		40'h0204081020, 40'h41417F0000, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7F48444438, 40'h3844444420, 40'h384444487F,
		40'h3854545418, 40'h087E090102, 40'h081454543C,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h007F102844, 40'h00417F4000, 40'h7C04180478,
		40'h7C08040478, 40'h3844444438, 40'h7C14141408,
		40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
		40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000,
		40'h0041360800, 40'h08082A1C08
	};

	// Glyph cell bits, column outer and row inner, first cell in bit 0
	function automatic glyph_t glyph_bits(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] c;
		logic [6:0] idx;
		logic [39:0] cols;
		glyph_t g;
		c = ((code < CHAR_FIRST) || (code > CHAR_LAST)) ? CHAR_FIRST : code;
		idx = 7'(c - CHAR_FIRST);
		cols = GLYPH_ROM[idx];
		for (int k = 0; k < GLYPH_COLS; k++) begin
			g[k*GLYPH_ROWS +: GLYPH_ROWS] = cols[(GLYPH_COLS-1-k)*8 +: GLYPH_ROWS];
		end
		return g;
	endfunction

endpackage

// File: rtl/font_glyph_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// font_glyph_rasterizer_unit
// 5x7 bitmap font character generator: one pixel write per set glyph bit on screen.
// ----------------------------------------------------------------------------
// Pixel items: each on-screen set cell is held until the next one or the end of
//   the walk, then moves into the output register.
// Walk: one of the 35 cells is tested per cycle unless a stalled output holds it
//   back; a new character is taken only after load, walk and flush are done.
// Reset: cursor clears, width 160, height 128, no items pending.
module font_glyph_rasterizer_unit #(
	parameter int unsigned MAX_SCREEN_DIM = fgr_pkg::MAX_SCREEN_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fgr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fgr_pkg::DIM_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [fgr_pkg::CODE_W-1:0]           char_code,
	input  logic                                 first_char,
	input  logic signed [fgr_pkg::COORD_W-1:0]   text_x,
	input  logic signed [fgr_pkg::COORD_W-1:0]   text_y,
	input  logic [fgr_pkg::COLOR_W-1:0]          ink_color,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fgr_pkg::PIX_W-1:0]            pix_x,
	output logic [fgr_pkg::PIX_W-1:0]            pix_y,
	output logic [fgr_pkg::ADDR_W-1:0]           pix_addr,
	output logic [fgr_pkg::COLOR_W-1:0]          pix_color,
	output logic                                 last_pixel
);

	fgr_pkg::fgr_cmd_t cmd;
	fgr_pkg::fgr_stat_t stat;

	assign cfg_ready = 1'b1;

	fgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	fgr_dp #(
		.MAX_SCREEN_DIM (MAX_SCREEN_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_code  (char_code),
		.first_char (first_char),
		.text_x     (text_x),
		.text_y     (text_y),
		.ink_color  (ink_color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.pix_addr   (pix_addr),
		.pix_color  (pix_color),
		.last_pixel (last_pixel),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

// File: rtl/fgr_ctrl.sv
// ----------------------------------------------------------------------------
// fgr_ctrl
// Sequencer: load one character, walk its 35 glyph cells, flush the held pixel.
// ----------------------------------------------------------------------------
module fgr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fgr_pkg::fgr_stat_t stat,
	output fgr_pkg::fgr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.step_ok) begin
					cmd.step = 1'b1;
					if (stat.last_cell) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (stat.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SCAN))
		else $error("load did not start a scan");

	a_flush_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.flush) |-> $past(cmd.step && stat.last_cell))
		else $error("flush entered without finishing the cell walk");

	a_idle_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) && stat.flush_ok |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

endmodule

// File: rtl/fgr_dp.sv
// ----------------------------------------------------------------------------
// fgr_dp
// Datapath: config registers, cursor, glyph cell walk, held pixel, output item.
// ----------------------------------------------------------------------------
module fgr_dp #(
	parameter int unsigned MAX_SCREEN_DIM = fgr_pkg::MAX_SCREEN_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [fgr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fgr_pkg::DIM_W-1:0]            cfg_data,
	input  logic [fgr_pkg::CODE_W-1:0]           char_code,
	input  logic                                 first_char,
	input  logic signed [fgr_pkg::COORD_W-1:0]   text_x,
	input  logic signed [fgr_pkg::COORD_W-1:0]   text_y,
	input  logic [fgr_pkg::COLOR_W-1:0]          ink_color,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fgr_pkg::PIX_W-1:0]            pix_x,
	output logic [fgr_pkg::PIX_W-1:0]            pix_y,
	output logic [fgr_pkg::ADDR_W-1:0]           pix_addr,
	output logic [fgr_pkg::COLOR_W-1:0]          pix_color,
	output logic                                 last_pixel,
	input  fgr_pkg::fgr_cmd_t                    cmd,
	output fgr_pkg::fgr_stat_t                   stat
);

	localparam int unsigned DIM_LIM =
		(MAX_SCREEN_DIM < fgr_pkg::PIX_SPAN) ? MAX_SCREEN_DIM : fgr_pkg::PIX_SPAN;
	localparam logic [fgr_pkg::DIM_W-1:0] DIM_LIM_V = fgr_pkg::DIM_W'(DIM_LIM);
	localparam int unsigned SUM_W = fgr_pkg::COORD_W + 1;

	logic [fgr_pkg::DIM_W-1:0] width_q, height_q;
	logic [fgr_pkg::DIM_W-1:0] wdt_q, hgt_q;
	logic signed [fgr_pkg::COORD_W-1:0] cursor_q, x0_q, y0_q;
	logic signed [fgr_pkg::COORD_W-1:0] x0_d;
	logic [fgr_pkg::COLOR_W-1:0] color_q;
	fgr_pkg::glyph_t glyph_q;
	logic [2:0] col_q, row_q;

	logic signed [SUM_W-1:0] px, py;
	logic hit;
	logic [fgr_pkg::ADDR_W-1:0] addr;

	logic pend_valid_q;
	logic [fgr_pkg::PIX_W-1:0] pend_x_q, pend_y_q;
	logic [fgr_pkg::ADDR_W-1:0] pend_addr_q;

	logic out_valid_q, out_last_q;
	logic [fgr_pkg::PIX_W-1:0] out_x_q, out_y_q;
	logic [fgr_pkg::ADDR_W-1:0] out_addr_q;
	logic [fgr_pkg::COLOR_W-1:0] out_color_q;

	logic out_busy, out_fire, move_pend;

	assign x0_d = first_char ? text_x : cursor_q;

	assign px = SUM_W'(x0_q) + SUM_W'(signed'({1'b0, col_q}));
	assign py = SUM_W'(y0_q) + SUM_W'(signed'({1'b0, row_q}));

	assign hit = glyph_q[0]
		&& (px >= 0) && (px < signed'(SUM_W'(wdt_q)))
		&& (py >= 0) && (py < signed'(SUM_W'(hgt_q)));

	assign addr = fgr_pkg::ADDR_W'(py[fgr_pkg::PIX_W-1:0] * wdt_q)
		+ fgr_pkg::ADDR_W'(px[fgr_pkg::PIX_W-1:0]);

	assign out_busy = out_valid_q && out_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign move_pend = pend_valid_q && !out_busy && ((cmd.step && hit) || cmd.flush);

	assign stat.step_ok = !(hit && pend_valid_q && out_busy);
	assign stat.last_cell = (col_q == 3'(fgr_pkg::GLYPH_COLS - 1))
		&& (row_q == 3'(fgr_pkg::GLYPH_ROWS - 1));
	assign stat.flush_ok = !pend_valid_q || !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= fgr_pkg::WIDTH_RST;
			height_q <= fgr_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fgr_pkg::REG_SCREEN_WIDTH: width_q <= cfg_data;
				fgr_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cmd.load) begin
			cursor_q <= (x0_d > (fgr_pkg::CURSOR_TOP - fgr_pkg::CHAR_ADVANCE))
				? fgr_pkg::CURSOR_TOP : x0_d + fgr_pkg::CHAR_ADVANCE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= x0_d;
			y0_q <= text_y;
			color_q <= ink_color;
			glyph_q <= fgr_pkg::glyph_bits(char_code);
			wdt_q <= (width_q > DIM_LIM_V) ? DIM_LIM_V : width_q;
			hgt_q <= (height_q > DIM_LIM_V) ? DIM_LIM_V : height_q;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.step) begin
			glyph_q <= glyph_q >> 1;
			if (row_q == 3'(fgr_pkg::GLYPH_ROWS - 1)) begin
				row_q <= '0;
				col_q <= col_q + 3'd1;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.step && hit) begin
			pend_valid_q <= 1'b1;
		end else if (move_pend) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && hit) begin
			pend_x_q <= px[fgr_pkg::PIX_W-1:0];
			pend_y_q <= py[fgr_pkg::PIX_W-1:0];
			pend_addr_q <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_pend) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_pend) begin
			out_x_q <= pend_x_q;
			out_y_q <= pend_y_q;
			out_addr_q <= pend_addr_q;
			out_color_q <= color_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign pix_x = out_x_q;
	assign pix_y = out_y_q;
	assign pix_addr = out_addr_q;
	assign pix_color = out_color_q;
	assign last_pixel = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		move_pend |-> !out_busy)
		else $error("output item overwritten while stalled");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_valid_q)
		else $error("held pixel left over from previous item");

	a_pend_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_valid_q) |-> $past(cmd.step))
		else $error("held pixel set outside the cell walk");

endmodule
